>>> design/weq_pkg.sv
// Shared types and constants for the windowed event queue.
// Used by the channel interfaces and by the queue module.
`timescale 1ns / 1ps
`default_nettype none

package weq_pkg;

   // Defaults for the top level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF   = 48;

   // Fixed payload widths of the channels
   localparam int EVENT_TIME_W = 48;
   localparam int DATA_W       = 64;
   localparam int LEN_W        = 16;
   localparam int SPACE_W      = 8;
   localparam int OFFSET_W     = 16;
   localparam int PEND_W       = 5;
   localparam int DROP_W       = 32;

   // Request command codes
   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   // Response word kinds
   typedef enum logic [1:0] {
      KIND_EVENT = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_FULL  = 2'd2
   } kind_type;

endpackage

`default_nettype wire

>>> design/weq_req_if.sv
// Request channel of the windowed event queue: valid/ready plus request word.
// Depends on weq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface weq_req_if;
   import weq_pkg::*;

   logic                    valid;
   logic                    ready;
   cmd_type                 cmd;
   logic [EVENT_TIME_W-1:0] event_time;
   logic [DATA_W-1:0]       event_data;
   logic [EVENT_TIME_W-1:0] window_start;
   logic [LEN_W-1:0]        window_length;
   logic [SPACE_W-1:0]      out_space;

   modport source (
      output valid, cmd, event_time, event_data, window_start, window_length, out_space,
      input  ready
   );

   modport sink (
      input  valid, cmd, event_time, event_data, window_start, window_length, out_space,
      output ready
   );

endinterface

`default_nettype wire

>>> design/weq_rsp_if.sv
// Response channel of the windowed event queue: valid/ready plus response word.
// Depends on weq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface weq_rsp_if;
   import weq_pkg::*;

   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [OFFSET_W-1:0] time_offset;
   logic [DATA_W-1:0]   out_data;
   logic [PEND_W-1:0]   pending_count;
   logic [DROP_W-1:0]   dropped_total;
   logic                last;

   modport source (
      output valid, kind, time_offset, out_data, pending_count, dropped_total, last,
      input  ready
   );

   modport sink (
      input  valid, kind, time_offset, out_data, pending_count, dropped_total, last,
      output ready
   );

endinterface

`default_nettype wire

>>> design/weq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module weq_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/windowed_event_queue.sv
// Windowed event queue: a bounded ring of timestamped events with a
// drop-oldest overflow policy and a windowed drain.
// Depends on weq_pkg, weq_req_if, weq_rsp_if and weq_ram.
//
// Usage:
//  - req_chan carries push and drain words (valid/ready). A push gives no
//    response; ready stays high, so pushes can follow back to back.
//  - A drain gives the in-window events in queue order on rsp_chan, then one
//    status word with last set (done, or stopped because output was full).
//  - A drain walks the ring twice through one read port and one window
//    compare unit: a counting pass to learn the final fill level (reported
//    on every word of the drain), then an emit/compact pass. Each entry goes
//    through a read state and an evaluate state in each pass, and the emit
//    pass holds while a response is stalled; ready is low for the whole drain.
//  - rsp_chan is driven from an output register. When the receiver stalls,
//    the sequencer holds on the pending word and resumes when it is taken.
//  - Reset empties the queue and clears the drop counter; no clearing pass
//    is needed since only filled slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module windowed_event_queue #(
   parameter int QUEUE_DEPTH = weq_pkg::QUEUE_DEPTH_DEF,
   parameter int TIME_BITS   = weq_pkg::TIME_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   weq_req_if.sink       req_chan,
   weq_rsp_if.source     rsp_chan
);

   import weq_pkg::*;

   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W = TIME_BITS + DATA_W;
   localparam int WIDE_W = TIME_BITS + EVENT_TIME_W;
   localparam int CMP_W  = CNT_W + SPACE_W;
   localparam int PX_W   = CNT_W + PEND_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_STATUS
   } state_type;

   // Ring index add with wrap at the queue depth
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic      pass2_ff, pass2_in;
   logic      blocked_ff, blocked_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] sent_ff, sent_in;
   logic [CNT_W-1:0] pend_ff, pend_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DROP_W-1:0] drops_ff, drops_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [SPACE_W-1:0] space_ff, space_in;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [PEND_W-1:0]   rsp_pend_ff, rsp_pend_in;
   logic [DROP_W-1:0]   rsp_drops_ff, rsp_drops_in;
   logic                rsp_last_ff, rsp_last_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [SLOT_W-1:0] mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;
   logic [SLOT_W-1:0] mem_rdata;

   logic [WIDE_W-1:0]    ev_wide;
   logic [WIDE_W-1:0]    start_wide;
   logic [TIME_BITS-1:0] slot_t;
   logic [DATA_W-1:0]    slot_d;
   logic [TIME_BITS:0]   diff;
   logic                 older;
   logic                 in_win;
   logic                 block_hit;
   logic                 keep;
   logic                 emit;
   logic                 last_entry;
   logic                 out_free;
   logic                 full;
   logic [CNT_W-1:0]     wr_step;
   logic [PX_W-1:0]      pend_wide;

   // Slot storage: {time, data} per entry
   weq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Times are kept to TIME_BITS bits
   assign ev_wide    = WIDE_W'(req_chan.event_time);
   assign start_wide = WIDE_W'(req_chan.window_start);

   // Walk address follows the read pointer
   assign mem_raddr = ring_add(head_ff, rd_ff);

   // Shared window compare unit on the slot just read
   assign slot_t    = mem_rdata[SLOT_W-1:DATA_W];
   assign slot_d    = mem_rdata[DATA_W-1:0];
   assign diff      = {1'b0, slot_t} - {1'b0, start_ff};
   assign older     = diff[TIME_BITS];
   assign in_win    = !older && (diff[TIME_BITS-1:OFFSET_W] == '0) &&
                      (diff[OFFSET_W-1:0] < len_ff);
   assign block_hit = !blocked_ff && in_win && (CMP_W'(sent_ff) >= CMP_W'(space_ff));
   assign keep      = blocked_ff || (!older && !in_win) || block_hit;
   assign emit      = !blocked_ff && in_win && !block_hit;

   assign last_entry = (CNT_W'(rd_ff) + CNT_W'(1)) == count_ff;
   assign wr_step    = wr_ff + CNT_W'(keep);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pend_wide  = PX_W'(pend_ff);

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      pass2_in      = pass2_ff;
      blocked_in    = blocked_ff;
      rd_in         = rd_ff;
      head_in       = head_ff;
      wr_in         = wr_ff;
      sent_in       = sent_ff;
      pend_in       = pend_ff;
      count_in      = count_ff;
      drops_in      = drops_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      space_in      = space_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_drops_in  = rsp_drops_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = ring_add(head_ff, wr_ff[IDX_W-1:0]);
      mem_wdata     = {slot_t, slot_d};

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.cmd == CMD_PUSH) begin
                  // Append; a full ring overwrites its oldest slot
                  mem_we    = 1'b1;
                  mem_wdata = {ev_wide[TIME_BITS-1:0], req_chan.event_data};
                  if (full) begin
                     mem_waddr = head_ff;
                     head_in   = ring_add(head_ff, IDX_W'(1));
                     if (drops_ff != '1) begin
                        drops_in = drops_ff + DROP_W'(1);
                     end
                  end else begin
                     mem_waddr = ring_add(head_ff, count_ff[IDX_W-1:0]);
                     count_in  = count_ff + CNT_W'(1);
                  end
               end else begin
                  start_in   = start_wide[TIME_BITS-1:0];
                  len_in     = req_chan.window_length;
                  space_in   = req_chan.out_space;
                  pass2_in   = 1'b0;
                  blocked_in = 1'b0;
                  rd_in      = '0;
                  wr_in      = '0;
                  sent_in    = '0;
                  if (count_ff == '0) begin
                     pend_in  = '0;
                     state_in = ST_STATUS;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end

         ST_READ: begin
            // Read data lands next cycle
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            if (!pass2_ff) begin
               // Counting pass: learn the final fill level
               wr_in = wr_step;
               if (emit) begin
                  sent_in = sent_ff + CNT_W'(1);
               end
               if (block_hit) begin
                  blocked_in = 1'b1;
               end
               state_in = ST_READ;
               if (last_entry) begin
                  pend_in    = wr_step;
                  pass2_in   = 1'b1;
                  rd_in      = '0;
                  wr_in      = '0;
                  sent_in    = '0;
                  blocked_in = 1'b0;
               end else begin
                  rd_in = rd_ff + IDX_W'(1);
               end
            end else if (!emit || out_free) begin
               // Emit pass: send in-window entries, compact kept ones
               if (keep) begin
                  mem_we = 1'b1;
                  wr_in  = wr_step;
               end
               if (emit) begin
                  sent_in       = sent_ff + CNT_W'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_EVENT;
                  rsp_offset_in = diff[OFFSET_W-1:0];
                  rsp_data_in   = slot_d;
                  rsp_pend_in   = pend_wide[PEND_W-1:0];
                  rsp_drops_in  = drops_ff;
                  rsp_last_in   = 1'b0;
               end
               if (block_hit) begin
                  blocked_in = 1'b1;
               end
               if (last_entry) begin
                  state_in = ST_STATUS;
               end else begin
                  rd_in    = rd_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end

         ST_STATUS: begin
            // Closing status word and commit of the new fill level
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = blocked_ff ? KIND_FULL : KIND_DONE;
               rsp_offset_in = '0;
               rsp_data_in   = '0;
               rsp_pend_in   = pend_wide[PEND_W-1:0];
               rsp_drops_in  = drops_ff;
               rsp_last_in   = 1'b1;
               count_in      = pend_ff;
               pass2_in      = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass2_ff     <= 1'b0;
         blocked_ff   <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         drops_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass2_ff     <= pass2_in;
         blocked_ff   <= blocked_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         drops_ff     <= drops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      sent_ff       <= sent_in;
      pend_ff       <= pend_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      space_ff      <= space_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pend_ff   <= rsp_pend_in;
      rsp_drops_ff  <= rsp_drops_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_chan.ready         = state_ff == ST_IDLE;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.time_offset   = rsp_offset_ff;
   assign rsp_chan.out_data      = rsp_data_ff;
   assign rsp_chan.pending_count = rsp_pend_ff;
   assign rsp_chan.dropped_total = rsp_drops_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

`default_nettype wire
